// File: hdl/sqfs_pkg.sv
package sqfs_pkg;

  // Field and register widths
  localparam int SAMPLE_W    = 32;
  localparam int STEP_W      = 32;
  localparam int HLIM_W      = 6;
  localparam int AMP_W       = 16;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 32;

  // Shared multiplier operand width
  localparam int MUL_W = 32;

  // Q0.15 magnitudes of sine and coefficient, their product and the sum
  localparam int SINE_W = 15;
  localparam int COEF_W = 15;
  localparam int TERM_W = 30;
  localparam int ACC_W  = 40;

  // Register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP     = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_HARMONIC_LIMIT = CFG_INDEX_W'(1);

  // Reset values
  localparam logic [STEP_W-1:0] PHASE_STEP_RESET     = STEP_W'(683565);
  localparam logic [HLIM_W-1:0] HARMONIC_LIMIT_RESET = HLIM_W'(1);

  // Q2.30 constants
  localparam logic [63:0] HALF_PI_Q30     = 64'd1686629713;
  localparam logic [63:0] TWO_OVER_PI_Q30 = 64'd683565276;
  localparam logic [63:0] ONE_Q30         = 64'd1073741824;

  // Accumulator start (one half in Q.30) and rounding bias for Q2.14
  localparam logic signed [ACC_W-1:0] ACC_HALF   = ACC_W'(64'd536870912);
  localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(64'd32768);
  localparam int ROUND_SHIFT = 16;

  localparam logic signed [AMP_W-1:0] AMP_MAX = 16'sh7FFF;
  localparam logic signed [AMP_W-1:0] AMP_MIN = 16'sh8000;

endpackage

// File: hdl/sqfs_sine_rom.sv
module sqfs_sine_rom #(
  parameter int ADDR_BITS = 10
) (
  input  logic                        clk,
  input  logic [ADDR_BITS-1:0]        addr,
  output logic [sqfs_pkg::SINE_W-1:0] data
);

  localparam int DEPTH = 1 << ADDR_BITS;
  localparam int unsigned TAYLOR_DIV [6] = '{156, 110, 72, 42, 20, 6};

  typedef logic [sqfs_pkg::SINE_W-1:0] sine_table_t [DEPTH];

  // Quarter wave, sampled at the centre of each address step
  function automatic sine_table_t build_table();
    sine_table_t tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    for (int a = 0; a < DEPTH; a++) begin
      x  = (sqfs_pkg::HALF_PI_Q30 * (64'(2 * a) + 64'd1)) >> (ADDR_BITS + 1);
      x2 = (x * x) >> 30;
      t  = sqfs_pkg::ONE_Q30;
      for (int i = 0; i < 6; i++) begin
        t = sqfs_pkg::ONE_Q30 - (((x2 * t) >> 30) / 64'(TAYLOR_DIV[i]));
      end
      s = (x * t) >> 30;
      v = (s * 64'd32767 + (sqfs_pkg::ONE_Q30 >> 1)) >> 30;
      tab[a] = v[sqfs_pkg::SINE_W-1:0];
    end
    return tab;
  endfunction

  localparam sine_table_t SINE_TABLE = build_table();

  always_ff @(posedge clk) begin
    data <= SINE_TABLE[addr];
  end

endmodule

// File: hdl/sqfs_mult.sv
module sqfs_mult (
  input  logic                         clk,
  input  logic                         en,
  input  logic [sqfs_pkg::MUL_W-1:0]   a,
  input  logic [sqfs_pkg::MUL_W-1:0]   b,
  output logic [2*sqfs_pkg::MUL_W-1:0] p
);

  // Hold the product until the next enabled cycle
  always_ff @(posedge clk) begin
    if (en) begin
      p <= a * b;
    end
  end

endmodule

// File: hdl/square_wave_fourier_synth.sv
// Square wave Fourier synthesiser: one sample of the truncated series
//   1/2 + sum over odd k <= K of 2/(k*pi) * sin(k*t),  t = index * phase_step.
// Input channel: in_valid/in_stall carry a sample_index request. The block
// takes one request at a time and holds in_stall high while it works.
// Output channel: out_valid/out_stall carry amplitude (signed Q2.14,
// saturated). The result sits in an output register; while the receiver
// stalls it holds, and a new request is taken and worked on meanwhile, its
// result waiting in the sequencer until the register frees up.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0
// is phase_step, index 1 harmonic_limit, other indexes are dropped. Write
// only while idle.
// One shared 32x32 multiplier does the work: index*phase_step first, then
// one coefficient*sine product per odd harmonic, n = (min(harmonic_limit,
// MAX_HARMONIC) + 1) / 2 of them, fed by the quarter wave ROM and
// coefficient table through a three-deep pipeline.
// Reset (rst, synchronous): sequencer idle, no result pending, registers
// back to phase_step = 683565 and harmonic_limit = 1.
module square_wave_fourier_synth #(
  parameter int MAX_HARMONIC   = 63,
  parameter int SINE_ADDR_BITS = 10,
  parameter int PHASE_BITS     = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [sqfs_pkg::SAMPLE_W-1:0]      sample_index,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [sqfs_pkg::AMP_W-1:0]  amplitude,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sqfs_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [sqfs_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // Number of odd harmonics the table covers and counter widths
  localparam int NUM_ODD = (MAX_HARMONIC + 1) / 2;
  localparam int CNT_W   = $clog2(NUM_ODD + 1);
  localparam int IDX_W   = (NUM_ODD > 1) ? $clog2(NUM_ODD) : 1;
  localparam int LIM_W   = ($clog2(MAX_HARMONIC + 1) > sqfs_pkg::HLIM_W) ?
                           $clog2(MAX_HARMONIC + 1) : sqfs_pkg::HLIM_W;

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PHASE = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_RUN   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  typedef logic [sqfs_pkg::COEF_W-1:0] coef_table_t [NUM_ODD];

  // Shift-and-subtract division, run at elaboration only
  function automatic logic [29:0] udiv30(input logic [29:0] num, input logic [8:0] den);
    logic [9:0]  rem;
    logic [29:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 29; i >= 0; i--) begin
      rem = {rem[8:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // 2/(k*pi) in Q0.15 for k = 1, 3, 5, ...
  function automatic coef_table_t build_coef();
    coef_table_t tab;
    logic [30:0] sum;
    for (int j = 0; j < NUM_ODD; j++) begin
      sum = {1'b0, udiv30(sqfs_pkg::TWO_OVER_PI_Q30[29:0], 9'(2 * j + 1))} + 31'd16384;
      tab[j] = sum[15 +: sqfs_pkg::COEF_W];
    end
    return tab;
  endfunction

  localparam coef_table_t COEF_TABLE = build_coef();

  // Configuration registers
  logic [sqfs_pkg::STEP_W-1:0] phase_step;
  logic [sqfs_pkg::HLIM_W-1:0] harmonic_limit;

  // Sequencer and datapath registers
  logic [2:0]                        state;
  logic [2:0]                        state_next;
  logic [sqfs_pkg::SAMPLE_W-1:0]     sample;
  logic [PHASE_BITS-1:0]             phase;
  logic [PHASE_BITS-1:0]             angle;
  logic [CNT_W-1:0]                  issue_cnt;
  logic                              v1;
  logic                              v2;
  logic                              sgn1;
  logic                              sgn2;
  logic [sqfs_pkg::COEF_W-1:0]       coef_q;
  logic signed [sqfs_pkg::ACC_W-1:0] acc;

  // Combinational
  logic [LIM_W-1:0]                  lim;
  logic [LIM_W:0]                    lim_sum;
  logic [CNT_W-1:0]                  n_terms;
  logic                              issue;
  logic [1:0]                        quadrant;
  logic [SINE_ADDR_BITS-1:0]         rom_addr;
  logic [sqfs_pkg::SINE_W-1:0]       rom_q;
  logic                              mul_en;
  logic [sqfs_pkg::MUL_W-1:0]        mul_a;
  logic [sqfs_pkg::MUL_W-1:0]        mul_b;
  logic [2*sqfs_pkg::MUL_W-1:0]      prod;
  logic signed [sqfs_pkg::ACC_W-1:0] term;
  logic signed [sqfs_pkg::ACC_W-1:0] rsum;
  logic signed [sqfs_pkg::ACC_W-1:0] rshift;
  logic signed [sqfs_pkg::AMP_W-1:0] amp_sat;
  logic                              out_load;

  assign in_stall  = rst || (state != S_IDLE);
  assign cfg_ready = !rst;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step     <= sqfs_pkg::PHASE_STEP_RESET;
      harmonic_limit <= sqfs_pkg::HARMONIC_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sqfs_pkg::REG_PHASE_STEP:     phase_step     <= cfg_data[sqfs_pkg::STEP_W-1:0];
        sqfs_pkg::REG_HARMONIC_LIMIT: harmonic_limit <= cfg_data[sqfs_pkg::HLIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the limit to the table and count the odd harmonics up to it
  always_comb begin
    lim = LIM_W'(harmonic_limit);
    if (lim > LIM_W'(MAX_HARMONIC)) begin
      lim = LIM_W'(MAX_HARMONIC);
    end
    lim_sum = {1'b0, lim} + (LIM_W + 1)'(1);
    n_terms = lim_sum[CNT_W:1];
  end

  assign issue = (state == S_RUN) && (issue_cnt < n_terms);

  // Fold the angle onto the quarter wave: mirror in odd quadrants,
  // negate in the lower half turn
  assign quadrant = angle[PHASE_BITS-1 -: 2];
  assign rom_addr = quadrant[0] ? ~angle[PHASE_BITS-3 -: SINE_ADDR_BITS]
                                :  angle[PHASE_BITS-3 -: SINE_ADDR_BITS];

  sqfs_sine_rom #(
    .ADDR_BITS (SINE_ADDR_BITS)
  ) u_sine_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_q)
  );

  // One multiplier: index*step first, then coefficient*sine per harmonic
  assign mul_en = (state == S_PHASE) || v1;
  assign mul_a  = (state == S_PHASE) ? sample     : sqfs_pkg::MUL_W'(coef_q);
  assign mul_b  = (state == S_PHASE) ? phase_step : sqfs_pkg::MUL_W'(rom_q);

  sqfs_mult u_mult (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  assign term = sgn2 ? -sqfs_pkg::ACC_W'(prod[sqfs_pkg::TERM_W-1:0])
                     :  sqfs_pkg::ACC_W'(prod[sqfs_pkg::TERM_W-1:0]);

  // Round Q.30 to Q2.14 (floor after adding half an LSB) and saturate
  always_comb begin
    rsum   = acc + sqfs_pkg::ROUND_BIAS;
    rshift = rsum >>> sqfs_pkg::ROUND_SHIFT;
    if (rshift > sqfs_pkg::ACC_W'(sqfs_pkg::AMP_MAX)) begin
      amp_sat = sqfs_pkg::AMP_MAX;
    end else if (rshift < sqfs_pkg::ACC_W'(sqfs_pkg::AMP_MIN)) begin
      amp_sat = sqfs_pkg::AMP_MIN;
    end else begin
      amp_sat = rshift[sqfs_pkg::AMP_W-1:0];
    end
  end

  // Load the output register once it is free or being emptied
  assign out_load = (state == S_DONE) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid && !in_stall) state_next = S_PHASE;
      S_PHASE: state_next = S_LOAD;
      S_LOAD:  state_next = S_RUN;
      S_RUN:   if (!issue && !v1 && !v2) state_next = S_DONE;
      S_DONE:  if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      v1    <= issue;
      v2    <= v1;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      sample <= sample_index;
    end
    if (state == S_LOAD) begin
      phase     <= prod[PHASE_BITS-1:0];
      angle     <= prod[PHASE_BITS-1:0];
      issue_cnt <= '0;
      acc       <= sqfs_pkg::ACC_HALF;
    end else begin
      if (issue) begin
        // advance to the next odd harmonic: angle grows by twice the phase
        angle     <= angle + {phase[PHASE_BITS-2:0], 1'b0};
        issue_cnt <= issue_cnt + CNT_W'(1);
        coef_q    <= COEF_TABLE[issue_cnt[IDX_W-1:0]];
        sgn1      <= quadrant[1];
      end
      if (v1) begin
        sgn2 <= sgn1;
      end
      if (v2) begin
        acc <= acc + term;
      end
    end
    if (out_load) begin
      amplitude <= amp_sat;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) |-> (issue_cnt <= n_terms))
    else $error("harmonic counter ran past the term count");

  a_pipe_in_run: assert property (@(posedge clk) disable iff (rst)
    (v1 || v2) |-> (state == S_RUN))
    else $error("product pipeline busy outside the harmonic loop");

  a_done_drained: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> (!v1 && !v2 && (issue_cnt == n_terms)))
    else $error("result finished before all harmonics were summed");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_DONE))
    else $error("result presented without a finished sum");

endmodule
